// ===== rtl/rgbmm_pkg.sv =====
// Shared types and constants for the RGB min-max contrast stretch unit.
// Holds command codes, controller state, and controller/datapath structs.
// No dependencies.
package rgbmm_pkg;

   localparam int PIX_W   = 8;
   localparam int NUM_CH  = 3;
   localparam int PIXEL_W = PIX_W * NUM_CH;
   localparam int STEP_W  = 3;

   localparam logic [PIX_W-1:0] FULL_SCALE = 8'd255;
   localparam logic [STEP_W-1:0] LAST_STEP = 3'd7;

   typedef enum logic [1:0] {
      CMD_CLEAR  = 2'd0,
      CMD_GATHER = 2'd1,
      CMD_APPLY  = 2'd2
   } cmd_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIVIDE,
      ST_STORE
   } state_type;

   typedef struct packed {
      logic clear;
      logic gather;
      logic start;
      logic step;
      logic store;
   } ctl_cmd_type;

   typedef struct packed {
      logic out_busy;
   } dp_status_type;

endpackage

// ===== rtl/rgbmm_datapath.sv =====
// Datapath: per-channel statistics, three restoring-divider lanes, output register.
// Depends on rgbmm_pkg; driven by rgbmm_controller commands.
module rgbmm_datapath (
   input  logic                           clock,
   input  logic                           reset,
   input  rgbmm_pkg::ctl_cmd_type         cmd,
   input  logic [rgbmm_pkg::PIXEL_W-1:0]  pix_in,
   input  logic                           rsp_tready,
   output logic                           rsp_tvalid,
   output logic [rgbmm_pkg::PIXEL_W-1:0]  rsp_tdata,
   output rgbmm_pkg::dp_status_type       status
);
   import rgbmm_pkg::*;

   logic [PIX_W-1:0]   low_ff   [NUM_CH];
   logic [PIX_W-1:0]   low_in   [NUM_CH];
   logic [PIX_W-1:0]   high_ff  [NUM_CH];
   logic [PIX_W-1:0]   high_in  [NUM_CH];

   logic [PIX_W-1:0]   rem_ff   [NUM_CH];
   logic [PIX_W-1:0]   rem_in   [NUM_CH];
   logic [PIX_W-1:0]   num_ff   [NUM_CH];
   logic [PIX_W-1:0]   num_in   [NUM_CH];
   logic [PIX_W-1:0]   quo_ff   [NUM_CH];
   logic [PIX_W-1:0]   quo_in   [NUM_CH];
   logic [PIX_W-1:0]   div_ff   [NUM_CH];
   logic [PIX_W-1:0]   div_in   [NUM_CH];
   logic               zero_ff  [NUM_CH];
   logic               zero_in  [NUM_CH];
   logic               sat_ff   [NUM_CH];
   logic               sat_in   [NUM_CH];

   logic               out_valid_ff;
   logic               out_valid_in;
   logic [PIXEL_W-1:0] out_data_ff;
   logic [PIXEL_W-1:0] out_data_in;

   logic [PIX_W-1:0]   pix      [NUM_CH];
   logic [PIX_W-1:0]   diff     [NUM_CH];
   logic [2*PIX_W-1:0] prod     [NUM_CH];
   logic [PIX_W:0]     trial    [NUM_CH];
   logic [PIX_W:0]     trial_sub[NUM_CH];

   always_comb begin
      for (int c = 0; c < NUM_CH; c++) begin
         pix[c]       = pix_in[c*PIX_W +: PIX_W];
         diff[c]      = pix[c] - low_ff[c];
         prod[c]      = {diff[c], {PIX_W{1'b0}}} - {{PIX_W{1'b0}}, diff[c]};
         trial[c]     = {rem_ff[c], num_ff[c][PIX_W-1]};
         trial_sub[c] = trial[c] - {1'b0, div_ff[c]};

         low_in[c]  = low_ff[c];
         high_in[c] = high_ff[c];
         rem_in[c]  = rem_ff[c];
         num_in[c]  = num_ff[c];
         quo_in[c]  = quo_ff[c];
         div_in[c]  = div_ff[c];
         zero_in[c] = zero_ff[c];
         sat_in[c]  = sat_ff[c];

         if (cmd.clear) begin
            low_in[c]  = FULL_SCALE;
            high_in[c] = '0;
         end else if (cmd.gather) begin
            if (pix[c] < low_ff[c]) begin
               low_in[c] = pix[c];
            end
            if (pix[c] > high_ff[c]) begin
               high_in[c] = pix[c];
            end
         end

         if (cmd.start) begin
            rem_in[c]  = prod[c][2*PIX_W-1:PIX_W];
            num_in[c]  = prod[c][PIX_W-1:0];
            quo_in[c]  = '0;
            div_in[c]  = high_ff[c] - low_ff[c];
            zero_in[c] = (high_ff[c] <= low_ff[c]) || (pix[c] <= low_ff[c]);
            sat_in[c]  = (pix[c] >= high_ff[c]);
         end else if (cmd.step) begin
            num_in[c] = {num_ff[c][PIX_W-2:0], 1'b0};
            if (trial[c] >= {1'b0, div_ff[c]}) begin
               rem_in[c] = trial_sub[c][PIX_W-1:0];
               quo_in[c] = {quo_ff[c][PIX_W-2:0], 1'b1};
            end else begin
               rem_in[c] = trial[c][PIX_W-1:0];
               quo_in[c] = {quo_ff[c][PIX_W-2:0], 1'b0};
            end
         end
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      out_data_in  = out_data_ff;
      if (out_valid_ff && rsp_tready) begin
         out_valid_in = 1'b0;
      end
      if (cmd.store) begin
         out_valid_in = 1'b1;
         for (int c = 0; c < NUM_CH; c++) begin
            if (zero_ff[c]) begin
               out_data_in[c*PIX_W +: PIX_W] = '0;
            end else if (sat_ff[c]) begin
               out_data_in[c*PIX_W +: PIX_W] = FULL_SCALE;
            end else begin
               out_data_in[c*PIX_W +: PIX_W] = quo_ff[c];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int c = 0; c < NUM_CH; c++) begin
            low_ff[c]  <= FULL_SCALE;
            high_ff[c] <= '0;
         end
         out_valid_ff <= 1'b0;
      end else begin
         low_ff       <= low_in;
         high_ff      <= high_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff      <= rem_in;
      num_ff      <= num_in;
      quo_ff      <= quo_in;
      div_ff      <= div_in;
      zero_ff     <= zero_in;
      sat_ff      <= sat_in;
      out_data_ff <= out_data_in;
   end

   assign rsp_tvalid      = out_valid_ff;
   assign rsp_tdata       = out_data_ff;
   assign status.out_busy = out_valid_ff && !rsp_tready;

endmodule

// ===== rtl/rgbmm_controller.sv =====
// Controller: sequences request acceptance, divider steps and result store.
// Depends on rgbmm_pkg; commands rgbmm_datapath.
module rgbmm_controller (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tvalid,
   input  logic [1:0]                req_cmd,
   input  rgbmm_pkg::dp_status_type  status,
   output logic                      req_tready,
   output rgbmm_pkg::ctl_cmd_type    cmd
);
   import rgbmm_pkg::*;

   state_type         state_ff;
   state_type         state_in;
   logic [STEP_W-1:0] step_ff;
   logic [STEP_W-1:0] step_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      step_in    = step_ff;
      req_tready = 1'b0;
      cmd        = '0;
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               case (req_cmd)
                  CMD_CLEAR:  cmd.clear  = 1'b1;
                  CMD_GATHER: cmd.gather = 1'b1;
                  CMD_APPLY: begin
                     cmd.start = 1'b1;
                     step_in   = '0;
                     state_in  = ST_DIVIDE;
                  end
                  default: ;
               endcase
            end
         end
         ST_DIVIDE: begin
            cmd.step = 1'b1;
            step_in  = step_ff + 1'b1;
            if (step_ff == LAST_STEP) begin
               state_in = ST_STORE;
            end
         end
         ST_STORE: begin
            if (!status.out_busy) begin
               cmd.store = 1'b1;
               state_in  = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

endmodule

// ===== rtl/rgb_min_max_contrast_stretch_unit.sv =====
// Top level of the RGB min-max contrast stretch unit.
// Instantiates rgbmm_controller and rgbmm_datapath; uses rgbmm_pkg.
//
// Channel  Direction  Handshake          Payload
// req      in         req_tvalid/tready  tuser: cmd; tdata: red, green, blue
// rsp      out        rsp_tvalid/tready  tdata: red_out, green_out, blue_out
//
// Clear and gather are applied as they are accepted. Apply runs as accept, eight
// steps of the per-channel restoring divider (one quotient bit each), then the result store.
// Synchronous active-high reset sets minimums to 255 and maximums to 0.
// A result held by a stalled rsp side holds the store; new requests are taken
// while a stored result waits.
module rgb_min_max_contrast_stretch_unit (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [1:0]                     req_tuser,  // [1:0] cmd
   input  logic [rgbmm_pkg::PIXEL_W-1:0]  req_tdata,  // [7:0] red, [15:8] green, [23:16] blue
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [rgbmm_pkg::PIXEL_W-1:0]  rsp_tdata   // [7:0] red_out, [15:8] green_out,
                                                      // [23:16] blue_out
);
   import rgbmm_pkg::*;

   ctl_cmd_type   ctl_cmd;
   dp_status_type dp_status;

   rgbmm_controller u_controller (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_cmd    (req_tuser),
      .status     (dp_status),
      .req_tready (req_tready),
      .cmd        (ctl_cmd)
   );

   rgbmm_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (ctl_cmd),
      .pix_in     (req_tdata),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tdata  (rsp_tdata),
      .status     (dp_status)
   );

   a_store_free: assert property (@(posedge clock) disable iff (reset)
      ctl_cmd.store |-> !dp_status.out_busy)
      else $error("result stored over a stalled result");

   a_rise_from_store: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(ctl_cmd.store))
      else $error("result valid without a store");

   a_apply_blocks: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && req_tuser == CMD_APPLY) |=> !req_tready)
      else $error("request taken during a divide");

   a_step_busy: assert property (@(posedge clock) disable iff (reset)
      ctl_cmd.step |-> !req_tready && !ctl_cmd.store)
      else $error("divider step while idle");

endmodule
